[hw/rtl/fpp_pkg.sv]
// ----------------------------------------------------------------------------
// fpp_pkg: shared types and constants of the packet header parser
// Header byte offsets, status codes, register indexes and the records that
// move between the capture, decode and output stages.
// ----------------------------------------------------------------------------
`default_nettype none

package fpp_pkg;

    // Header geometry. Only bytes 0x00..0x35 feed the decoder.
    localparam int HDR_BYTES = 58;
    localparam int HDR_KEEP  = 54;
    localparam int CNT_W     = 6;

    // Byte offsets of the little-endian header fields
    localparam int OFS_ONODE      = 'h00;
    localparam int OFS_DNODE      = 'h02;
    localparam int OFS_PKT_TYPE   = 'h12;
    localparam int OFS_ONET       = 'h14;
    localparam int OFS_DNET       = 'h16;
    localparam int OFS_PROD_LO    = 'h18;
    localparam int OFS_VER_HI     = 'h19;
    localparam int OFS_PWD        = 'h1a;
    localparam int OFS_OZONE_OLD  = 'h22;
    localparam int OFS_DZONE_OLD  = 'h24;
    localparam int OFS_CAP_SWAP   = 'h28;
    localparam int OFS_PROD_HI    = 'h2a;
    localparam int OFS_VER_LO     = 'h2b;
    localparam int OFS_CAP        = 'h2c;
    localparam int OFS_OZONE_PLUS = 'h2e;
    localparam int OFS_DZONE_PLUS = 'h30;
    localparam int OFS_OPOINT     = 'h32;
    localparam int OFS_DPOINT     = 'h34;

    localparam logic [15:0] PKT_TYPE_2   = 16'h0002;
    localparam logic [15:0] CAP_PLUS_BIT = 16'h0001;
    localparam logic [7:0]  PWD_SPACE    = 8'h20;

    // Configuration
    localparam int MASK_W    = 4;
    localparam int ADDR_W    = 64;
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_MASK  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ADDR0 = 3'd1;

    // Result status codes
    localparam logic [2:0] STAT_OK_PLUS   = 3'd0;
    localparam logic [2:0] STAT_OK_OLD    = 3'd1;
    localparam logic [2:0] STAT_BAD_TYPE  = 3'd2;
    localparam logic [2:0] STAT_SHORT     = 3'd3;
    localparam logic [2:0] STAT_NOT_LOCAL = 3'd4;

    // Result beat layout on the output tdata
    localparam int RES_W            = 227;
    localparam int M_TDATA_W        = 232;
    localparam int OUT_STATUS_LSB   = 0;
    localparam int OUT_OPOINT_LSB   = 51;
    localparam int OUT_DPOINT_LSB   = 115;
    localparam int OUT_VERSION_LSB  = 147;

    // Header fields captured when the last header byte arrives or the packet ends early
    typedef struct packed {
        logic [15:0] orig_node;
        logic [15:0] dest_node;
        logic [15:0] pkt_type;
        logic [15:0] orig_net;
        logic [15:0] dest_net;
        logic [7:0]  prod_lo;
        logic [7:0]  ver_hi;
        logic [63:0] pwd;
        logic [15:0] ozone_old;
        logic [15:0] dzone_old;
        logic [15:0] cap_swap;
        logic [7:0]  prod_hi;
        logic [7:0]  ver_lo;
        logic [15:0] cap;
        logic [15:0] ozone_plus;
        logic [15:0] dzone_plus;
        logic [15:0] opoint;
        logic [15:0] dpoint;
    } hdr_t;

    typedef struct packed {
        logic valid;
        logic short_hdr;
    } snap_stat_t;

    // Packed so that status sits in the lowest bits of the output beat
    typedef struct packed {
        logic [63:0] password;
        logic [15:0] version;
        logic [15:0] product_code;
        logic [15:0] dest_point;
        logic [15:0] dest_node;
        logic [15:0] dest_net;
        logic [15:0] dest_zone;
        logic [15:0] orig_point;
        logic [15:0] orig_node;
        logic [15:0] orig_net;
        logic [15:0] orig_zone;
        logic [2:0]  status;
    } result_t;

endpackage

`default_nettype wire

[hw/rtl/fpp_cfg_regs.sv]
// ----------------------------------------------------------------------------
// fpp_cfg_regs: local address configuration registers
// Holds the slot valid mask and the local address slots.
// ----------------------------------------------------------------------------
`default_nettype none

module fpp_cfg_regs #(
    parameter int SLOTS = 4
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  wr_en,
    input  wire logic [fpp_pkg::CFG_IDX_W-1:0]         wr_index,
    input  wire logic [fpp_pkg::ADDR_W-1:0]            wr_data,
    output logic      [fpp_pkg::MASK_W-1:0]            mask,
    output logic      [((SLOTS < fpp_pkg::MASK_W) ? SLOTS : fpp_pkg::MASK_W)-1:0]
                      [fpp_pkg::ADDR_W-1:0]            addr
);

    // Slots past the mask width can never be marked valid, so they are not kept.
    localparam int ACTIVE = (SLOTS < fpp_pkg::MASK_W) ? SLOTS : fpp_pkg::MASK_W;

    logic [fpp_pkg::MASK_W-1:0] mask_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg <= '0;
        end
        else if (wr_en && (wr_index == fpp_pkg::REG_MASK))
        begin
            mask_reg <= wr_data[fpp_pkg::MASK_W-1:0];
        end
    end

    for (genvar s = 0; s < ACTIVE; s++)
    begin : g_slot
        logic [fpp_pkg::ADDR_W-1:0] addr_reg;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                addr_reg <= '0;
            end
            else if (wr_en &&
                     (wr_index == fpp_pkg::CFG_IDX_W'(int'(fpp_pkg::REG_ADDR0) + s)))
            begin
                addr_reg <= wr_data;
            end
        end

        assign addr[s] = addr_reg;
    end

    assign mask = mask_reg;

endmodule

`default_nettype wire

[hw/rtl/fpp_capture.sv]
// ----------------------------------------------------------------------------
// fpp_capture: header byte capture and framing
// Counts header bytes, stores the ones the decoder needs and snapshots them
// when the header completes or the packet ends early.
// ----------------------------------------------------------------------------
`default_nettype none

module fpp_capture (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                beat_valid,
    input  wire logic [7:0]          beat_byte,
    input  wire logic                beat_last,
    input  wire logic                snap_take,
    output logic                     in_ready,
    output fpp_pkg::snap_stat_t      snap_stat,
    output fpp_pkg::hdr_t            snap_hdr
);

    logic [fpp_pkg::CNT_W-1:0] count_reg;
    logic [fpp_pkg::CNT_W-1:0] count_next;
    logic                      done_reg;
    logic                      done_next;
    logic [7:0]                store_reg [fpp_pkg::HDR_KEEP];
    logic                      snap_valid_reg;
    logic                      snap_short_reg;
    fpp_pkg::hdr_t             snap_hdr_reg;
    logic                      accept;
    logic                      hdr_end;
    logic                      short_end;
    logic                      snap_load;
    fpp_pkg::hdr_t             hdr_next;

    // A beat is taken whenever the snapshot slot is or is about to be free.
    assign in_ready = !snap_valid_reg || snap_take;
    assign accept   = beat_valid && in_ready;

    assign hdr_end   = !done_reg && (count_reg == fpp_pkg::CNT_W'(fpp_pkg::HDR_BYTES - 1));
    assign short_end = !done_reg && !hdr_end && beat_last;
    assign snap_load = accept && (hdr_end || short_end);

    always_comb
    begin
        count_next = count_reg;
        done_next  = done_reg;
        if (done_reg)
        begin
            // Bytes after the header are dropped until the packet ends.
            if (beat_last)
            begin
                done_next  = 1'b0;
                count_next = '0;
            end
        end
        else if (hdr_end)
        begin
            count_next = '0;
            done_next  = !beat_last;
        end
        else if (beat_last)
        begin
            count_next = '0;
        end
        else
        begin
            count_next = count_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else if (accept)
        begin
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && !done_reg && (count_reg < fpp_pkg::CNT_W'(fpp_pkg::HDR_KEEP)))
        begin
            store_reg[count_reg] <= beat_byte;
        end
    end

    // The final header byte is not among the decoded fields, so the stored
    // bytes are complete on the edge that accepts it.
    always_comb
    begin
        hdr_next.orig_node  = {store_reg[fpp_pkg::OFS_ONODE + 1],
                               store_reg[fpp_pkg::OFS_ONODE]};
        hdr_next.dest_node  = {store_reg[fpp_pkg::OFS_DNODE + 1],
                               store_reg[fpp_pkg::OFS_DNODE]};
        hdr_next.pkt_type   = {store_reg[fpp_pkg::OFS_PKT_TYPE + 1],
                               store_reg[fpp_pkg::OFS_PKT_TYPE]};
        hdr_next.orig_net   = {store_reg[fpp_pkg::OFS_ONET + 1],
                               store_reg[fpp_pkg::OFS_ONET]};
        hdr_next.dest_net   = {store_reg[fpp_pkg::OFS_DNET + 1],
                               store_reg[fpp_pkg::OFS_DNET]};
        hdr_next.prod_lo    = store_reg[fpp_pkg::OFS_PROD_LO];
        hdr_next.ver_hi     = store_reg[fpp_pkg::OFS_VER_HI];
        hdr_next.pwd        = {store_reg[fpp_pkg::OFS_PWD + 7],
                               store_reg[fpp_pkg::OFS_PWD + 6],
                               store_reg[fpp_pkg::OFS_PWD + 5],
                               store_reg[fpp_pkg::OFS_PWD + 4],
                               store_reg[fpp_pkg::OFS_PWD + 3],
                               store_reg[fpp_pkg::OFS_PWD + 2],
                               store_reg[fpp_pkg::OFS_PWD + 1],
                               store_reg[fpp_pkg::OFS_PWD]};
        hdr_next.ozone_old  = {store_reg[fpp_pkg::OFS_OZONE_OLD + 1],
                               store_reg[fpp_pkg::OFS_OZONE_OLD]};
        hdr_next.dzone_old  = {store_reg[fpp_pkg::OFS_DZONE_OLD + 1],
                               store_reg[fpp_pkg::OFS_DZONE_OLD]};
        // The swapped copy of the capability word has its high byte first.
        hdr_next.cap_swap   = {store_reg[fpp_pkg::OFS_CAP_SWAP],
                               store_reg[fpp_pkg::OFS_CAP_SWAP + 1]};
        hdr_next.prod_hi    = store_reg[fpp_pkg::OFS_PROD_HI];
        hdr_next.ver_lo     = store_reg[fpp_pkg::OFS_VER_LO];
        hdr_next.cap        = {store_reg[fpp_pkg::OFS_CAP + 1],
                               store_reg[fpp_pkg::OFS_CAP]};
        hdr_next.ozone_plus = {store_reg[fpp_pkg::OFS_OZONE_PLUS + 1],
                               store_reg[fpp_pkg::OFS_OZONE_PLUS]};
        hdr_next.dzone_plus = {store_reg[fpp_pkg::OFS_DZONE_PLUS + 1],
                               store_reg[fpp_pkg::OFS_DZONE_PLUS]};
        hdr_next.opoint     = {store_reg[fpp_pkg::OFS_OPOINT + 1],
                               store_reg[fpp_pkg::OFS_OPOINT]};
        hdr_next.dpoint     = {store_reg[fpp_pkg::OFS_DPOINT + 1],
                               store_reg[fpp_pkg::OFS_DPOINT]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            snap_valid_reg <= 1'b0;
        end
        else if (snap_load)
        begin
            snap_valid_reg <= 1'b1;
        end
        else if (snap_take)
        begin
            snap_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (snap_load)
        begin
            snap_short_reg <= short_end;
            snap_hdr_reg   <= hdr_next;
        end
    end

    assign snap_stat.valid     = snap_valid_reg;
    assign snap_stat.short_hdr = snap_short_reg;
    assign snap_hdr            = snap_hdr_reg;

endmodule

`default_nettype wire

[hw/rtl/fpp_decode.sv]
// ----------------------------------------------------------------------------
// fpp_decode: header field decoder
// Turns a captured header into the result record: packet style, zone guess,
// password trim and the local address match.
// ----------------------------------------------------------------------------
`default_nettype none

module fpp_decode #(
    parameter int SLOTS = 4
) (
    input  wire fpp_pkg::hdr_t                         hdr,
    input  wire logic                                  short_hdr,
    input  wire logic [fpp_pkg::MASK_W-1:0]            mask,
    input  wire logic [((SLOTS < fpp_pkg::MASK_W) ? SLOTS : fpp_pkg::MASK_W)-1:0]
                      [fpp_pkg::ADDR_W-1:0]            addr,
    output fpp_pkg::result_t                           res
);

    localparam int ACTIVE = (SLOTS < fpp_pkg::MASK_W) ? SLOTS : fpp_pkg::MASK_W;

    logic        plus;
    logic        guess_hit;
    logic [15:0] guess_zone;
    logic [15:0] oz;
    logic [15:0] dz;
    logic [15:0] dp;
    logic        to_us;
    logic [8:0]  tail_sp;
    logic [63:0] pwd;

    // 2+ only when the capability word matches its byte-swapped copy.
    assign plus = (hdr.cap == hdr.cap_swap) && ((hdr.cap & fpp_pkg::CAP_PLUS_BIT) != '0);

    // Lowest-numbered valid slot on the destination net/node wins the guess.
    always_comb
    begin
        guess_hit  = 1'b0;
        guess_zone = '0;
        for (int s = ACTIVE - 1; s >= 0; s--)
        begin
            if (mask[s] && (hdr.dest_net == addr[s][47:32]) &&
                (hdr.dest_node == addr[s][31:16]))
            begin
                guess_hit  = 1'b1;
                guess_zone = addr[s][63:48];
            end
        end
    end

    always_comb
    begin
        if (plus)
        begin
            oz = hdr.ozone_plus;
            dz = hdr.dzone_plus;
            dp = hdr.dpoint;
        end
        else if ((hdr.ozone_old == '0) && (hdr.dzone_old == '0) && guess_hit)
        begin
            oz = guess_zone;
            dz = guess_zone;
            dp = '0;
        end
        else
        begin
            oz = hdr.ozone_old;
            dz = hdr.dzone_old;
            dp = '0;
        end
    end

    // Trailing spaces of the password become zero bytes.
    always_comb
    begin
        tail_sp[8] = 1'b1;
        for (int k = 7; k >= 0; k--)
        begin
            tail_sp[k] = tail_sp[k+1] && (hdr.pwd[8*k +: 8] == fpp_pkg::PWD_SPACE);
        end
        for (int k = 0; k < 8; k++)
        begin
            pwd[8*k +: 8] = tail_sp[k] ? 8'h00 : hdr.pwd[8*k +: 8];
        end
    end

    always_comb
    begin
        to_us = 1'b0;
        for (int s = 0; s < ACTIVE; s++)
        begin
            if (mask[s] && ((dz == '0) || (dz == addr[s][63:48])) &&
                (hdr.dest_net == addr[s][47:32]) && (hdr.dest_node == addr[s][31:16]) &&
                (!plus || (dp == addr[s][15:0]) || ((dp != '0) && (addr[s][15:0] == '0))))
            begin
                to_us = 1'b1;
            end
        end
    end

    always_comb
    begin
        res = '0;
        if (short_hdr)
        begin
            res.status = fpp_pkg::STAT_SHORT;
        end
        else if (hdr.pkt_type != fpp_pkg::PKT_TYPE_2)
        begin
            res.status = fpp_pkg::STAT_BAD_TYPE;
        end
        else
        begin
            if (!to_us)
            begin
                res.status = fpp_pkg::STAT_NOT_LOCAL;
            end
            else if (plus)
            begin
                res.status = fpp_pkg::STAT_OK_PLUS;
            end
            else
            begin
                res.status = fpp_pkg::STAT_OK_OLD;
            end
            res.orig_zone    = oz;
            res.orig_net     = hdr.orig_net;
            res.orig_node    = hdr.orig_node;
            res.orig_point   = plus ? hdr.opoint : 16'h0000;
            res.dest_zone    = dz;
            res.dest_net     = hdr.dest_net;
            res.dest_node    = hdr.dest_node;
            res.dest_point   = dp;
            res.product_code = {plus ? hdr.prod_hi : 8'h00, hdr.prod_lo};
            res.version      = {hdr.ver_hi, plus ? hdr.ver_lo : 8'h00};
            res.password     = pwd;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/fido_packet_header_parser_top.sv]
// ----------------------------------------------------------------------------
// fido_packet_header_parser_top: mail packet header parser
// Takes a packet byte stream and gives one decoded header beat per packet.
//
//   Channel   Dir  Beat content
//   s_axis    in   tdata[7:0] data_byte, tlast end_of_input
//   m_axis    out  tdata: status, origin/destination addresses, product,
//                  version, password (one result per packet)
//   cfg       in   cfg_index selects the register, cfg_data the value
//
// One input beat is taken per cycle unless the input stalls. A result
// passes from the beat that ends the header or the packet through the
// capture snapshot and the combinational decoder into the result register.
// Reset clears the byte counter, the framing flag, both valid flags and the
// configuration. The input stalls only while the snapshot and the result
// register both hold results that the output has not taken.
// ----------------------------------------------------------------------------
`default_nettype none

module fido_packet_header_parser_top #(
    parameter int LOCAL_ADDRESS_SLOTS = 4
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    input  wire logic [7:0]                        s_axis_tdata,  // [7:0] data_byte
    input  wire logic                              s_axis_tlast,
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    // [2:0] status, [18:3] orig_zone, [34:19] orig_net, [50:35] orig_node,
    // [66:51] orig_point, [82:67] dest_zone, [98:83] dest_net,
    // [114:99] dest_node, [130:115] dest_point, [146:131] product_code,
    // [162:147] version, [226:163] password, [231:227] zero
    output logic [fpp_pkg::M_TDATA_W-1:0]          m_axis_tdata,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [fpp_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [fpp_pkg::ADDR_W-1:0]        cfg_data
);

    localparam int ACTIVE = (LOCAL_ADDRESS_SLOTS < fpp_pkg::MASK_W) ?
                            LOCAL_ADDRESS_SLOTS : fpp_pkg::MASK_W;

    logic [fpp_pkg::MASK_W-1:0]             mask;
    logic [ACTIVE-1:0][fpp_pkg::ADDR_W-1:0] addr;
    fpp_pkg::snap_stat_t                    snap_stat;
    fpp_pkg::hdr_t                          snap_hdr;
    fpp_pkg::result_t                       res_next;
    fpp_pkg::result_t                       res_reg;
    logic                                   out_valid_reg;
    logic                                   res_load;

    assign cfg_ready = 1'b1;

    fpp_cfg_regs #(
        .SLOTS (LOCAL_ADDRESS_SLOTS)
    ) u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .mask     (mask),
        .addr     (addr)
    );

    // The result register refills whenever it is empty or being drained.
    assign res_load = snap_stat.valid && (!out_valid_reg || m_axis_tready);

    fpp_capture u_capture (
        .clk        (clk),
        .rst_n      (rst_n),
        .beat_valid (s_axis_tvalid),
        .beat_byte  (s_axis_tdata),
        .beat_last  (s_axis_tlast),
        .snap_take  (res_load),
        .in_ready   (s_axis_tready),
        .snap_stat  (snap_stat),
        .snap_hdr   (snap_hdr)
    );

    fpp_decode #(
        .SLOTS (LOCAL_ADDRESS_SLOTS)
    ) u_decode (
        .hdr       (snap_hdr),
        .short_hdr (snap_stat.short_hdr),
        .mask      (mask),
        .addr      (addr),
        .res       (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            res_reg <= res_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {(fpp_pkg::M_TDATA_W - fpp_pkg::RES_W)'(0), res_reg};

endmodule

`default_nettype wire

[hw/rtl/fpp_checker.sv]
// ----------------------------------------------------------------------------
// fpp_checker: port-level checks of the packet header parser
// Watches the result channel for stable stalled beats and for result
// records whose fields disagree with their status.
// ----------------------------------------------------------------------------
`default_nettype none

module fpp_checker (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    input  wire logic [fpp_pkg::M_TDATA_W-1:0]     m_axis_tdata
);

    logic [2:0] status;

    assign status = m_axis_tdata[fpp_pkg::OUT_STATUS_LSB +: 3];

    // A stalled result beat holds its content.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result beat changed while stalled");

    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (status == fpp_pkg::STAT_OK_PLUS) ||
                          (status == fpp_pkg::STAT_OK_OLD) ||
                          (status == fpp_pkg::STAT_BAD_TYPE) ||
                          (status == fpp_pkg::STAT_SHORT) ||
                          (status == fpp_pkg::STAT_NOT_LOCAL))
        else $error("result status out of range");

    // Rejected headers carry nothing but their status.
    a_reject_empty: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && ((status == fpp_pkg::STAT_BAD_TYPE) ||
                          (status == fpp_pkg::STAT_SHORT))
        |-> (m_axis_tdata[fpp_pkg::M_TDATA_W-1:3] == '0))
        else $error("rejected header beat carries field data");

    // Old-style packets have no points and no minor version.
    a_old_style: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (status == fpp_pkg::STAT_OK_OLD)
        |-> (m_axis_tdata[fpp_pkg::OUT_OPOINT_LSB +: 16] == '0) &&
            (m_axis_tdata[fpp_pkg::OUT_DPOINT_LSB +: 16] == '0) &&
            (m_axis_tdata[fpp_pkg::OUT_VERSION_LSB +: 8] == '0))
        else $error("old-style result carries point or minor version");

    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[fpp_pkg::M_TDATA_W-1:fpp_pkg::RES_W] == '0))
        else $error("result pad bits not zero");

endmodule

bind fido_packet_header_parser_top fpp_checker u_fpp_checker (.*);

`default_nettype wire

[sim/fido_packet_header_parser_checker.sv]
// ----------------------------------------------------------------------------
// fido_packet_header_parser_checker: result predictor and scoreboard
// Watches the configuration, byte and result channels of the packet header
// parser, keeps its own copy of the header bytes and the local addresses,
// predicts one result per header or cut-short packet, and compares every
// result beat field by field with the oldest prediction.
// ----------------------------------------------------------------------------
`default_nettype none

module fido_packet_header_parser_checker #(
    parameter int LOCAL_ADDRESS_SLOTS = 4
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              s_axis_tvalid,
    input  wire logic                              s_axis_tready,
    input  wire logic [7:0]                        s_axis_tdata,  // [7:0] data_byte
    input  wire logic                              s_axis_tlast,
    input  wire logic                              m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    input  wire logic [fpp_pkg::M_TDATA_W-1:0]     m_axis_tdata,  // result_t, then zeros
    input  wire logic                              cfg_valid,
    input  wire logic                              cfg_ready,
    input  wire logic [fpp_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [fpp_pkg::ADDR_W-1:0]        cfg_data,
    output int                                     error_count,
    output int                                     results_pending
);
    import fpp_pkg::*;

    logic [7:0]        header_bytes [HDR_BYTES];
    int                bytes_seen;
    bit                draining_tail;
    logic [MASK_W-1:0] slot_mask;
    logic [ADDR_W-1:0] slot_addr [MASK_W];
    result_t           expected_results [$];
    int                mismatches;

    assign error_count = mismatches;

    function automatic logic [15:0] header_word(input int ofs);
        return {header_bytes[ofs + 1], header_bytes[ofs]};
    endfunction

    function automatic bit slot_in_use(input int slot);
        return slot < LOCAL_ADDRESS_SLOTS && slot_mask[slot];
    endfunction

    // Decodes the 58 captured header bytes into the expected result beat.
    function automatic result_t decode_header();
        result_t     r;
        logic [15:0] cap;
        logic [15:0] swapped;
        logic [15:0] slot_point;
        logic [7:0]  pwd_byte;
        bit          plus;
        bit          zone_found;
        bit          trimming;
        bit          for_us;
        r = '0;
        if (header_word(OFS_PKT_TYPE) != PKT_TYPE_2)
        begin
            r.status = STAT_BAD_TYPE;
            return r;
        end
        r.orig_node    = header_word(OFS_ONODE);
        r.dest_node    = header_word(OFS_DNODE);
        r.orig_net     = header_word(OFS_ONET);
        r.dest_net     = header_word(OFS_DNET);
        r.product_code = {8'h00, header_bytes[OFS_PROD_LO]};
        r.version      = {header_bytes[OFS_VER_HI], 8'h00};

        // The capability word only counts when its byte-swapped copy agrees.
        cap     = header_word(OFS_CAP);
        swapped = {header_bytes[OFS_CAP_SWAP], header_bytes[OFS_CAP_SWAP + 1]};
        plus    = (cap == swapped) && ((cap & CAP_PLUS_BIT) != 16'h0000);

        if (plus)
        begin
            r.product_code[15:8] = header_bytes[OFS_PROD_HI];
            r.version[7:0]       = header_bytes[OFS_VER_LO];
            r.orig_zone          = header_word(OFS_OZONE_PLUS);
            r.dest_zone          = header_word(OFS_DZONE_PLUS);
            r.orig_point         = header_word(OFS_OPOINT);
            r.dest_point         = header_word(OFS_DPOINT);
        end
        else
        begin
            r.orig_zone = header_word(OFS_OZONE_OLD);
            r.dest_zone = header_word(OFS_DZONE_OLD);
            // A zoneless old-style packet borrows the zone of the first local
            // address in use that carries the destination net and node.
            if (r.orig_zone == 16'h0000 && r.dest_zone == 16'h0000)
            begin
                zone_found = 1'b0;
                for (int s = 0; s < MASK_W; s++)
                begin
                    if (!zone_found && slot_in_use(s) &&
                        slot_addr[s][47:32] == r.dest_net &&
                        slot_addr[s][31:16] == r.dest_node)
                    begin
                        r.dest_zone = slot_addr[s][63:48];
                        r.orig_zone = r.dest_zone;
                        zone_found  = 1'b1;
                    end
                end
            end
        end

        // Only the trailing run of spaces is cleared.
        trimming = 1'b1;
        for (int k = 7; k >= 0; k--)
        begin
            pwd_byte = header_bytes[OFS_PWD + k];
            if (trimming && pwd_byte == PWD_SPACE)
                pwd_byte = 8'h00;
            else
                trimming = 1'b0;
            r.password[8*k +: 8] = pwd_byte;
        end

        for_us = 1'b0;
        for (int s = 0; s < MASK_W; s++)
        begin
            slot_point = slot_addr[s][15:0];
            if (slot_in_use(s) &&
                (r.dest_zone == 16'h0000 || r.dest_zone == slot_addr[s][63:48]) &&
                r.dest_net == slot_addr[s][47:32] &&
                r.dest_node == slot_addr[s][31:16] &&
                (!plus || r.dest_point == slot_point ||
                 (r.dest_point != 16'h0000 && slot_point == 16'h0000)))
                for_us = 1'b1;
        end
        r.status = for_us ? (plus ? STAT_OK_PLUS : STAT_OK_OLD) : STAT_NOT_LOCAL;
        return r;
    endfunction

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (got !== want)
        begin
            mismatches++;
            $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        result_t got;
        result_t want;
        result_t cut_short;
        if (!rst_n)
        begin
            bytes_seen      = 0;
            draining_tail   = 1'b0;
            slot_mask       = '0;
            for (int s = 0; s < MASK_W; s++)
                slot_addr[s] = '0;
            expected_results.delete();
            mismatches      = 0;
            results_pending = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_MASK)
                    slot_mask = cfg_data[MASK_W-1:0];
                else if (cfg_index >= REG_ADDR0 && cfg_index < REG_ADDR0 + MASK_W &&
                         cfg_index - REG_ADDR0 < LOCAL_ADDRESS_SLOTS)
                    slot_addr[cfg_index - REG_ADDR0] = cfg_data;
            end

            if (s_axis_tvalid && s_axis_tready)
            begin
                // Bytes past a complete header are dropped up to the end of the packet.
                if (draining_tail)
                begin
                    if (s_axis_tlast)
                        draining_tail = 1'b0;
                end
                else
                begin
                    header_bytes[bytes_seen] = s_axis_tdata;
                    bytes_seen++;
                    if (bytes_seen == HDR_BYTES)
                    begin
                        expected_results.push_back(decode_header());
                        bytes_seen    = 0;
                        draining_tail = !s_axis_tlast;
                    end
                    else if (s_axis_tlast)
                    begin
                        cut_short        = '0;
                        cut_short.status = STAT_SHORT;
                        expected_results.push_back(cut_short);
                        bytes_seen = 0;
                    end
                end
            end

            if (m_axis_tvalid && m_axis_tready)
            begin
                got = m_axis_tdata[RES_W-1:0];
                if (expected_results.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: result beat with nothing expected, expected none, got %h",
                             $time, m_axis_tdata);
                end
                else
                begin
                    want = expected_results.pop_front();
                    check_field("status", want.status, got.status);
                    check_field("orig_zone", want.orig_zone, got.orig_zone);
                    check_field("orig_net", want.orig_net, got.orig_net);
                    check_field("orig_node", want.orig_node, got.orig_node);
                    check_field("orig_point", want.orig_point, got.orig_point);
                    check_field("dest_zone", want.dest_zone, got.dest_zone);
                    check_field("dest_net", want.dest_net, got.dest_net);
                    check_field("dest_node", want.dest_node, got.dest_node);
                    check_field("dest_point", want.dest_point, got.dest_point);
                    check_field("product_code", want.product_code, got.product_code);
                    check_field("version", want.version, got.version);
                    check_field("password", want.password, got.password);
                    check_field("padding", '0, m_axis_tdata[M_TDATA_W-1:RES_W]);
                end
            end
            results_pending = expected_results.size();
        end
    end

endmodule

`default_nettype wire

[sim/fido_packet_header_parser_top_tb.sv]
// ----------------------------------------------------------------------------
// fido_packet_header_parser_top_tb: stimulus and verdict for the header parser
// Drives packet byte streams with bursty gaps against a receiver that stalls
// on its own pattern, changes the local addresses between phases, and leaves
// prediction and comparison to the checker beside the parser.
// ----------------------------------------------------------------------------
`default_nettype none

module fido_packet_header_parser_top_tb;
    import fpp_pkg::*;

    localparam int SLOTS        = 4;
    localparam int PHASE_ITEMS  = 240;
    localparam int HOLD_CYCLES  = 300;
    localparam int SETTLE       = 8;
    localparam int DRAIN_CYCLES = 12;
    localparam int IDLE_LIMIT   = 3000;

    typedef enum int {HDR_PLUS, HDR_OLD, HDR_OLD_ZONELESS, HDR_BAD_TYPE, HDR_NOISE} hdr_style_e;
    typedef enum int {ADDR_ALL_ZERO, ADDR_ALL_ONES, ADDR_NEARBY, ADDR_RANDOM} addr_kind_e;
    typedef enum int {READY_ALWAYS, READY_MOSTLY, READY_RARELY, READY_PERIODIC} stall_mode_e;

    logic                   clk;
    logic                   rst_n         = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [7:0]             s_axis_tdata  = '0;
    logic                   s_axis_tlast  = 1'b0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0]   m_axis_tdata;
    logic                   cfg_valid     = 1'b0;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index     = '0;
    logic [ADDR_W-1:0]      cfg_data      = '0;

    int                     check_errors;
    int                     results_pending;
    int                     idle_cycles   = 0;
    int                     items_sent    = 0;
    int                     burst_left    = 0;
    bit                     hold_request  = 1'b0;
    logic [7:0]             hdr_buf [HDR_BYTES];
    logic [ADDR_W-1:0]      addr_shadow [SLOTS];

    fido_packet_header_parser_top #(
        .LOCAL_ADDRESS_SLOTS (SLOTS)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    fido_packet_header_parser_checker #(
        .LOCAL_ADDRESS_SLOTS (SLOTS)
    ) checker_i (
        .clk             (clk),
        .rst_n           (rst_n),
        .s_axis_tvalid   (s_axis_tvalid),
        .s_axis_tready   (s_axis_tready),
        .s_axis_tdata    (s_axis_tdata),
        .s_axis_tlast    (s_axis_tlast),
        .m_axis_tvalid   (m_axis_tvalid),
        .m_axis_tready   (m_axis_tready),
        .m_axis_tdata    (m_axis_tdata),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .error_count     (check_errors),
        .results_pending (results_pending)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // Ends a run in which no channel has moved a beat for too long.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
                (cfg_valid && cfg_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    // Result receiver: switches between stall patterns, and once holds off
    // for a long stretch so that the parser backs up into its input.
    initial
    begin
        stall_mode_e mode;
        int          mode_left;
        int          tick;
        mode      = READY_ALWAYS;
        mode_left = 0;
        tick      = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                m_axis_tready <= 1'b0;
                for (int n = 1; n < HOLD_CYCLES; n++)
                    @(negedge clk);
                hold_request = 1'b0;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    mode      = stall_mode_e'($urandom_range(0, 3));
                    mode_left = $urandom_range(16, 160);
                end
                mode_left--;
                tick++;
                case (mode)
                    READY_ALWAYS:  m_axis_tready <= 1'b1;
                    READY_MOSTLY:  m_axis_tready <= ($urandom_range(0, 9) < 7);
                    READY_RARELY:  m_axis_tready <= ($urandom_range(0, 3) == 0);
                    default:       m_axis_tready <= ((tick % 9) < 5);
                endcase
            end
        end
    end

    // Offers one byte and returns at the falling edge after it was taken.
    // Valid stays high between bytes of a burst.
    task automatic send_byte(input logic [7:0] b, input logic lst);
        if (burst_left == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge clk);
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(1, 24);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= lst;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        @(negedge clk);
        burst_left--;
    endtask

    // Sends the first len bytes of hdr_buf, then tail extra bytes. When
    // closed is clear the packet never gets its end marker.
    task automatic send_packet(input int len, input int tail, input bit closed);
        for (int i = 0; i < len; i++)
        begin
            send_byte(hdr_buf[i], closed && tail == 0 && i == len - 1);
            items_sent++;
        end
        for (int i = 0; i < tail; i++)
        begin
            send_byte(8'($urandom_range(0, 255)), closed && i == tail - 1);
            items_sent++;
        end
    endtask

    function automatic void put_word(input int ofs, input logic [15:0] w);
        hdr_buf[ofs]     = w[7:0];
        hdr_buf[ofs + 1] = w[15:8];
    endfunction

    task automatic make_header(input hdr_style_e style);
        int          slot;
        int          trail;
        logic [15:0] cap;
        logic [15:0] bad_type;
        logic [63:0] target;
        for (int i = 0; i < HDR_BYTES; i++)
            hdr_buf[i] = 8'($urandom_range(0, 255));
        if (style == HDR_NOISE)
        begin
            if ($urandom_range(0, 1))
                put_word(OFS_PKT_TYPE, PKT_TYPE_2);
            return;
        end
        if (style == HDR_BAD_TYPE)
        begin
            bad_type = 16'($urandom);
            if (bad_type == PKT_TYPE_2)
                bad_type = ~bad_type;
            put_word(OFS_PKT_TYPE, bad_type);
            return;
        end
        put_word(OFS_PKT_TYPE, PKT_TYPE_2);

        // Mostly aim at one of the local addresses.
        slot   = $urandom_range(0, SLOTS - 1);
        target = addr_shadow[slot];
        if ($urandom_range(0, 4) != 0)
        begin
            put_word(OFS_DNET, target[47:32]);
            put_word(OFS_DNODE, target[31:16]);
        end

        if (style == HDR_PLUS)
        begin
            cap = ($urandom_range(0, 1)) ? CAP_PLUS_BIT : (16'($urandom) | CAP_PLUS_BIT);
            put_word(OFS_CAP, cap);
            hdr_buf[OFS_CAP_SWAP]     = cap[15:8];
            hdr_buf[OFS_CAP_SWAP + 1] = cap[7:0];
            case ($urandom_range(0, 2))
                0:       put_word(OFS_DZONE_PLUS, 16'h0000);
                1:       put_word(OFS_DZONE_PLUS, target[63:48]);
                default: ;
            endcase
            case ($urandom_range(0, 2))
                0:       put_word(OFS_DPOINT, target[15:0]);
                1:       put_word(OFS_DPOINT, 16'h0000);
                default: ;
            endcase
        end
        else
        begin
            // Either an agreeing word without the 2+ bit, or a 2+ word whose
            // swapped copy does not agree.
            if ($urandom_range(0, 1))
            begin
                cap = 16'($urandom) & ~CAP_PLUS_BIT;
                put_word(OFS_CAP, cap);
                hdr_buf[OFS_CAP_SWAP]     = cap[15:8];
                hdr_buf[OFS_CAP_SWAP + 1] = cap[7:0];
            end
            else
            begin
                put_word(OFS_CAP, CAP_PLUS_BIT);
                put_word(OFS_CAP_SWAP, CAP_PLUS_BIT);
            end
            if (style == HDR_OLD_ZONELESS)
            begin
                put_word(OFS_OZONE_OLD, 16'h0000);
                put_word(OFS_DZONE_OLD, 16'h0000);
            end
            else if ($urandom_range(0, 1))
                put_word(OFS_DZONE_OLD, ($urandom_range(0, 1)) ? target[63:48] : 16'h0000);
        end

        trail = $urandom_range(0, 8);
        for (int k = 8 - trail; k < 8; k++)
            hdr_buf[OFS_PWD + k] = PWD_SPACE;
        if ($urandom_range(0, 3) == 0)
            hdr_buf[OFS_PWD + $urandom_range(0, 7)] = PWD_SPACE;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [ADDR_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        if (idx >= REG_ADDR0 && idx < REG_ADDR0 + SLOTS)
            addr_shadow[idx - REG_ADDR0] = val;
    endtask

    // Waits for the parser to drain, then rewrites every register.
    task automatic configure(input addr_kind_e kind, input logic [MASK_W-1:0] mask);
        logic [ADDR_W-1:0] addr;
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        while (results_pending != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
        write_reg(REG_MASK, {$urandom, 28'($urandom), mask});
        for (int i = 0; i < SLOTS; i++)
        begin
            case (kind)
                ADDR_ALL_ZERO: addr = '0;
                ADDR_ALL_ONES: addr = '1;
                ADDR_NEARBY:   addr = {16'($urandom_range(1, 3)), 16'($urandom_range(0, 7)),
                                       16'($urandom_range(0, 7)),
                                       ($urandom_range(0, 1)) ? 16'h0000
                                                              : 16'($urandom_range(1, 3))};
                default:       addr = {$urandom, $urandom};
            endcase
            write_reg(CFG_IDX_W'(int'(REG_ADDR0) + i), addr);
        end
        // An index past the address slots must leave everything alone.
        write_reg(CFG_IDX_W'(int'(REG_ADDR0) + SLOTS + int'($urandom_range(0, 2))),
                  {$urandom, $urandom});
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    task automatic random_traffic(input int quota);
        int pick;
        int base_count;
        base_count = items_sent;
        while (items_sent - base_count < quota)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 15)
            begin
                make_header(HDR_NOISE);
                send_packet(($urandom_range(0, 3) == 0) ? $urandom_range(9, HDR_BYTES - 1)
                                                        : $urandom_range(1, 8), 0, 1'b1);
            end
            else if (pick < 20)
            begin
                make_header(HDR_NOISE);
                send_packet(HDR_BYTES, $urandom_range(0, 4), 1'b1);
            end
            else if (pick < 24)
            begin
                make_header(HDR_PLUS);
                send_packet(HDR_BYTES, $urandom_range(0, 3), 1'b0);
            end
            else if (pick < 32)
            begin
                make_header(HDR_BAD_TYPE);
                send_packet(HDR_BYTES, $urandom_range(0, 2), 1'b1);
            end
            else
            begin
                make_header(hdr_style_e'($urandom_range(0, 2)));
                send_packet(HDR_BYTES, ($urandom_range(0, 1)) ? 0 : $urandom_range(1, 6), 1'b1);
            end
        end
    endtask

    initial
    begin
        for (int i = 0; i < SLOTS; i++)
            addr_shadow[i] = '0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        configure(ADDR_NEARBY, 4'hF);

        // Directed: shortest and longest cut-short packets.
        hdr_buf[0] = 8'hFF;
        send_packet(1, 0, 1'b1);
        make_header(HDR_PLUS);
        send_packet(HDR_BYTES - 1, 0, 1'b1);
        // End marker on the last header byte re-arms at once.
        make_header(HDR_PLUS);
        send_packet(HDR_BYTES, 0, 1'b1);
        make_header(HDR_OLD_ZONELESS);
        send_packet(HDR_BYTES, 3, 1'b1);
        make_header(HDR_OLD);
        send_packet(HDR_BYTES, 1, 1'b1);
        make_header(HDR_BAD_TYPE);
        send_packet(HDR_BYTES, 0, 1'b1);
        // All-ones header that still claims type 2 and a consistent 2+ word.
        for (int i = 0; i < HDR_BYTES; i++)
            hdr_buf[i] = 8'hFF;
        put_word(OFS_PKT_TYPE, PKT_TYPE_2);
        send_packet(HDR_BYTES, 0, 1'b1);
        // All-zero header of type 2: old style, zone taken from a matching local address if any.
        for (int i = 0; i < HDR_BYTES; i++)
            hdr_buf[i] = 8'h00;
        put_word(OFS_PKT_TYPE, PKT_TYPE_2);
        send_packet(HDR_BYTES, 0, 1'b1);
        // Password made only of spaces.
        make_header(HDR_PLUS);
        for (int k = 0; k < 8; k++)
            hdr_buf[OFS_PWD + k] = PWD_SPACE;
        send_packet(HDR_BYTES, 0, 1'b1);
        // A packet left open swallows the following short one up to its end.
        make_header(HDR_PLUS);
        send_packet(HDR_BYTES, 2, 1'b0);
        make_header(HDR_NOISE);
        send_packet(5, 0, 1'b1);

        configure(ADDR_ALL_ONES, 4'hF);
        random_traffic(PHASE_ITEMS);

        configure(ADDR_NEARBY, 4'h0);
        hold_request = 1'b1;
        for (int i = 0; i < 12; i++)
        begin
            make_header(HDR_NOISE);
            send_packet($urandom_range(1, 2), 0, 1'b1);
        end
        random_traffic(PHASE_ITEMS);

        configure(ADDR_ALL_ZERO, 4'hF);
        random_traffic(PHASE_ITEMS);

        configure(ADDR_RANDOM, 4'($urandom));
        random_traffic(PHASE_ITEMS);

        configure(ADDR_NEARBY, 4'($urandom_range(1, 15)));
        random_traffic(PHASE_ITEMS);

        s_axis_tvalid <= 1'b0;
        while (results_pending != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (check_errors == 0 && results_pending == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

`default_nettype wire

[sim.f]
hw/rtl/fpp_pkg.sv
hw/rtl/fpp_cfg_regs.sv
hw/rtl/fpp_capture.sv
hw/rtl/fpp_decode.sv
hw/rtl/fido_packet_header_parser_top.sv
hw/rtl/fpp_checker.sv
sim/fido_packet_header_parser_checker.sv
sim/fido_packet_header_parser_top_tb.sv
